// ----- rtl/mono_framebuffer_draw_engine_unit_assert.svh -----
// Assertion macros used by the draw engine RTL.
`ifndef MONO_FRAMEBUFFER_DRAW_ENGINE_UNIT_ASSERT_SVH
`define MONO_FRAMEBUFFER_DRAW_ENGINE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Checked while reset is low.
`define MFDE_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("draw engine assertion failed");
// Checked in every cycle, reset included.
`define MFDE_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("draw engine assertion failed");
`else
`define MFDE_ASSERT(lbl, prop)
`define MFDE_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ----- rtl/mfde_pkg.sv -----
// ----------------------------------------------------------------------------
// mfde_pkg
// Constants, types and font table of the monochrome framebuffer draw engine.
// ----------------------------------------------------------------------------
package mfde_pkg;

   localparam int DISP_WIDTH  = 128;
   localparam int DISP_HEIGHT = 64;
   localparam int CHUNK_BYTES = 16;

   localparam int FB_PAGES    = DISP_HEIGHT / 8;
   localparam int FB_SIZE     = DISP_WIDTH * FB_PAGES;
   localparam int STORE_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   // Chunk byte address: chunk index times chunk size plus offset.
   localparam int CHK_W       = 11;
   localparam int CNT_W       = 5;

   localparam logic [7:0] CTRL_CMD   = 8'h00;
   localparam logic [7:0] CTRL_DATA  = 8'h40;
   localparam logic [7:0] CMD_COLS   = 8'h21;
   localparam logic [7:0] CMD_PAGES  = 8'h22;
   localparam logic [7:0] BYTE_FULL  = 8'hFF;
   localparam logic [6:0] BUS_ADDR_RESET = 7'd60;

   typedef enum logic [2:0] {
      OP_FILL  = 3'd0,
      OP_PIXEL = 3'd1,
      OP_CHAR  = 3'd2,
      OP_HLINE = 3'd3,
      OP_VLINE = 3'd4,
      OP_RECT  = 3'd5,
      OP_WIN   = 3'd6,
      OP_CHUNK = 3'd7
   } op_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SEG,
      ST_LINE,
      ST_RMW,
      ST_CHAR,
      ST_WIN,
      ST_HDR,
      ST_CHK_RD,
      ST_CHK_OUT
   } state_type;

   typedef logic [0:4][7:0] glyph_type;

   function automatic glyph_type font_glyph(input logic [7:0] code_raw);
      logic [7:0] code;
      glyph_type  g;
      code = code_raw;
      if (code >= 8'h61 && code <= 8'h7A) begin
         code = code - 8'h20;
      end
      unique case (code)
         8'h30: g = {8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E};
         8'h31: g = {8'h00, 8'h42, 8'h7F, 8'h40, 8'h00};
         8'h32: g = {8'h42, 8'h61, 8'h51, 8'h49, 8'h46};
         8'h33: g = {8'h21, 8'h41, 8'h45, 8'h4B, 8'h31};
         8'h34: g = {8'h18, 8'h14, 8'h12, 8'h7F, 8'h10};
         8'h35: g = {8'h27, 8'h45, 8'h45, 8'h45, 8'h39};
         8'h36: g = {8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30};
         8'h37: g = {8'h01, 8'h71, 8'h09, 8'h05, 8'h03};
         8'h38: g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
         8'h39: g = {8'h06, 8'h49, 8'h49, 8'h29, 8'h1E};
         8'h41: g = {8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E};
         8'h42: g = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h36};
         8'h43: g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h22};
         8'h44: g = {8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C};
         8'h45: g = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h41};
         8'h46: g = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h01};
         8'h47: g = {8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A};
         8'h48: g = {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
         8'h49: g = {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
         8'h4A: g = {8'h20, 8'h40, 8'h41, 8'h3F, 8'h01};
         8'h4B: g = {8'h7F, 8'h08, 8'h14, 8'h22, 8'h41};
         8'h4C: g = {8'h7F, 8'h40, 8'h40, 8'h40, 8'h40};
         8'h4D: g = {8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F};
         8'h4E: g = {8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F};
         8'h4F: g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
         8'h50: g = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h06};
         8'h51: g = {8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E};
         8'h52: g = {8'h7F, 8'h09, 8'h19, 8'h29, 8'h46};
         8'h53: g = {8'h46, 8'h49, 8'h49, 8'h49, 8'h31};
         8'h54: g = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
         8'h55: g = {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
         8'h56: g = {8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F};
         8'h57: g = {8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F};
         8'h58: g = {8'h63, 8'h14, 8'h08, 8'h14, 8'h63};
         8'h59: g = {8'h07, 8'h08, 8'h70, 8'h08, 8'h07};
         8'h5A: g = {8'h61, 8'h51, 8'h49, 8'h45, 8'h43};
         8'h2D: g = {8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
         8'h5F: g = {8'h40, 8'h40, 8'h40, 8'h40, 8'h40};
         8'h2E: g = {8'h00, 8'h60, 8'h60, 8'h00, 8'h00};
         8'h3A: g = {8'h00, 8'h36, 8'h36, 8'h00, 8'h00};
         8'h20: g = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
         // Codes without a glyph draw a box.
         default: g = {8'h7F, 8'h41, 8'h5D, 8'h41, 8'h7F};
      endcase
      return g;
   endfunction

   function automatic logic [7:0] win_byte(input logic [2:0] k);
      logic [7:0] b;
      unique case (k)
         3'd0:    b = CTRL_CMD;
         3'd1:    b = CMD_COLS;
         3'd2:    b = 8'h00;
         3'd3:    b = 8'(DISP_WIDTH - 1);
         3'd4:    b = CMD_PAGES;
         3'd5:    b = 8'h00;
         3'd6:    b = 8'(FB_PAGES - 1);
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

// ----- rtl/mfde_if.sv -----
// ----------------------------------------------------------------------------
// mfde_if
// Request, response and register-write channels of the draw engine.
// ----------------------------------------------------------------------------
interface mfde_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] op;
   logic [7:0] pos_x;
   logic [7:0] pos_y;
   logic       pixel_on;
   logic [7:0] char_code;
   logic [7:0] span_w;
   logic [7:0] span_h;
   logic [5:0] chunk_index;
   modport source (output valid, op, pos_x, pos_y, pixel_on, char_code, span_w,
                   span_h, chunk_index, input ready);
   modport sink (input valid, op, pos_x, pos_y, pixel_on, char_code, span_w,
                 span_h, chunk_index, output ready);
endinterface

interface mfde_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       packet_first;
   logic       packet_last;
   logic [6:0] target_addr;
   modport source (output valid, out_byte, packet_first, packet_last, target_addr,
                   input ready);
   modport sink (input valid, out_byte, packet_first, packet_last, target_addr,
                 output ready);
endinterface

interface mfde_csr_if;
   logic       valid;
   logic       ready;
   logic [6:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// ----- rtl/mfde_ram.sv -----
// ----------------------------------------------------------------------------
// mfde_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mfde_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- rtl/mono_framebuffer_draw_engine_unit.sv -----
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_engine_unit
// Page-organized monochrome framebuffer with drawing ops and packet output.
// ----------------------------------------------------------------------------
// One request is handled at a time; ready is high only between requests. All
// framebuffer traffic goes through a single RAM port pair, so every pixel
// changed by a pixel, line, rectangle or character op is a read-modify-write:
// a read in ST_LINE or ST_CHAR, then the write in ST_RMW. A line has a setup
// state, a read and a write per visible pixel, a single step per clipped
// pixel and a closing state; a pixel op is a one-pixel line, a rectangle four
// such lines, a character 35 glyph positions with a read-modify-write for each
// lit one in range. Fill writes one byte per cycle; send window sends 7 bytes
// and send chunk the control byte, then a RAM read per data byte, waiting while
// the response side stalls. After reset the RAM is cleared before the first request.
module mono_framebuffer_draw_engine_unit
   import mfde_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   mfde_req_if.sink    req_chan,
   mfde_rsp_if.source  rsp_chan,
   mfde_csr_if.sink    csr_chan
);

`include "mono_framebuffer_draw_engine_unit_assert.svh"

   state_type          state_ff, state_in;
   op_type             op_ff, op_in;
   logic [7:0]         x_ff, x_in, y_ff, y_in, w_ff, w_in, h_ff, h_in;
   logic [7:0]         code_ff, code_in;
   logic               on_ff, on_in;
   logic [1:0]         seg_ff, seg_in;
   logic [7:0]         px_ff, px_in, py_ff, py_in, len_ff, len_in;
   logic               vert_ff, vert_in;
   logic [2:0]         col_ff, col_in, row_ff, row_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CHK_W-1:0]   base_ff, base_in;
   logic [ADDR_W-1:0]  sweep_ff, sweep_in;
   logic               sweep_all_ff, sweep_all_in;
   logic [7:0]         fill_val_ff, fill_val_in;
   logic [6:0]         bus_addr_ff, bus_addr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_byte_ff, rsp_byte_in;
   logic               rsp_first_ff, rsp_first_in, rsp_last_ff, rsp_last_in;

   logic               wr_en, rd_en;
   logic [ADDR_W-1:0]  wr_addr, rd_addr, pix_addr, sweep_end;
   logic [7:0]         wr_data, rd_data, pix_mask;
   logic               char_mode, in_range, glyph_bit, out_free, rsp_load;
   logic [7:0]         cur_x, cur_y;
   logic [CHK_W-1:0]   chk_addr, chunk_base;
   logic               chk_in_fb;
   glyph_type          glyph;

   mfde_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_frame_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Pixel under work: glyph position for characters, line walker otherwise.
   assign char_mode = (op_ff == OP_CHAR);
   assign cur_x     = char_mode ? x_ff + {5'd0, col_ff} : px_ff;
   assign cur_y     = char_mode ? y_ff + {5'd0, row_ff} : py_ff;
   assign in_range  = ({1'b0, cur_x} < 9'(DISP_WIDTH)) && ({1'b0, cur_y} < 9'(DISP_HEIGHT));
   assign pix_addr  = ADDR_W'(cur_x) + ADDR_W'(32'(cur_y[7:3]) * DISP_WIDTH);
   assign pix_mask  = 8'd1 << cur_y[2:0];
   assign glyph     = font_glyph(code_ff);
   assign glyph_bit = glyph[col_ff][row_ff];

   assign chk_addr   = base_ff + CHK_W'(cnt_ff);
   assign chk_in_fb  = chk_addr < CHK_W'(FB_SIZE);
   assign chunk_base = CHK_W'(32'(req_chan.chunk_index) * CHUNK_BYTES);
   assign sweep_end  = sweep_all_ff ? ADDR_W'(STORE_DEPTH - 1) : ADDR_W'(FB_SIZE - 1);

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign rd_addr  = (state_ff == ST_CHK_RD) ? chk_addr[ADDR_W-1:0] : pix_addr;

   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign csr_chan.ready        = 1'b1;
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.out_byte     = rsp_byte_ff;
   assign rsp_chan.packet_first = rsp_first_ff;
   assign rsp_chan.packet_last  = rsp_last_ff;
   assign rsp_chan.target_addr  = bus_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sweep_ff     <= '0;
         sweep_all_ff <= 1'b1;
         fill_val_ff  <= 8'h00;
         bus_addr_ff  <= BUS_ADDR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         sweep_all_ff <= sweep_all_in;
         fill_val_ff  <= fill_val_in;
         bus_addr_ff  <= bus_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      w_ff         <= w_in;
      h_ff         <= h_in;
      code_ff      <= code_in;
      on_ff        <= on_in;
      seg_ff       <= seg_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      len_ff       <= len_in;
      vert_ff      <= vert_in;
      col_ff       <= col_in;
      row_ff       <= row_in;
      cnt_ff       <= cnt_in;
      base_ff      <= base_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_first_ff <= rsp_first_in;
      rsp_last_ff  <= rsp_last_in;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      w_in         = w_ff;
      h_in         = h_ff;
      code_in      = code_ff;
      on_in        = on_ff;
      seg_in       = seg_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      len_in       = len_ff;
      vert_in      = vert_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      cnt_in       = cnt_ff;
      base_in      = base_ff;
      sweep_in     = sweep_ff;
      sweep_all_in = sweep_all_ff;
      fill_val_in  = fill_val_ff;
      bus_addr_in  = bus_addr_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_first_in = rsp_first_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_load     = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = pix_addr;
      wr_data      = (char_mode || on_ff) ? (rd_data | pix_mask) : (rd_data & ~pix_mask);
      rd_en        = 1'b0;

      if (csr_chan.valid) begin
         bus_addr_in = csr_chan.data;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en    = 1'b1;
            wr_addr  = sweep_ff;
            wr_data  = fill_val_ff;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == sweep_end) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_chan.valid) begin
               op_in   = op_type'(req_chan.op);
               x_in    = req_chan.pos_x;
               y_in    = req_chan.pos_y;
               w_in    = req_chan.span_w;
               h_in    = req_chan.span_h;
               code_in = req_chan.char_code;
               on_in   = req_chan.pixel_on;
               seg_in  = 2'd0;
               col_in  = 3'd0;
               row_in  = 3'd0;
               cnt_in  = '0;
               base_in = chunk_base;
               unique case (op_type'(req_chan.op))
                  OP_FILL: begin
                     sweep_in     = '0;
                     sweep_all_in = 1'b0;
                     fill_val_in  = req_chan.pixel_on ? BYTE_FULL : 8'h00;
                     state_in     = ST_CLEAR;
                  end
                  OP_CHAR:  state_in = ST_CHAR;
                  OP_WIN:   state_in = ST_WIN;
                  OP_CHUNK: begin
                     if (chunk_base < CHK_W'(FB_SIZE)) begin
                        state_in = ST_HDR;
                     end
                  end
                  OP_RECT: begin
                     if (req_chan.span_w != 8'd0 && req_chan.span_h != 8'd0) begin
                        state_in = ST_SEG;
                     end
                  end
                  default:  state_in = ST_SEG;
               endcase
            end
         end
         ST_SEG: begin
            px_in    = x_ff;
            py_in    = y_ff;
            vert_in  = 1'b0;
            state_in = ST_LINE;
            unique case (op_ff)
               OP_HLINE: len_in = w_ff;
               OP_VLINE: begin
                  len_in  = h_ff;
                  vert_in = 1'b1;
               end
               OP_RECT: begin
                  unique case (seg_ff)
                     2'd0: len_in = w_ff;
                     2'd1: begin
                        py_in  = y_ff + h_ff - 8'd1;
                        len_in = w_ff;
                     end
                     2'd2: begin
                        len_in  = h_ff;
                        vert_in = 1'b1;
                     end
                     default: begin
                        px_in   = x_ff + w_ff - 8'd1;
                        len_in  = h_ff;
                        vert_in = 1'b1;
                     end
                  endcase
               end
               default: len_in = 8'd1;
            endcase
         end
         ST_LINE: begin
            if (len_ff == 8'd0) begin
               if (op_ff == OP_RECT && seg_ff != 2'd3) begin
                  seg_in   = seg_ff + 2'd1;
                  state_in = ST_SEG;
               end else begin
                  state_in = ST_IDLE;
               end
            end else if (in_range) begin
               rd_en    = 1'b1;
               state_in = ST_RMW;
            end else begin
               px_in  = vert_ff ? px_ff : px_ff + 8'd1;
               py_in  = vert_ff ? py_ff + 8'd1 : py_ff;
               len_in = len_ff - 8'd1;
            end
         end
         ST_RMW: begin
            wr_en = 1'b1;
            if (char_mode) begin
               state_in = ST_CHAR;
               if (row_ff == 3'd6) begin
                  row_in = 3'd0;
                  col_in = col_ff + 3'd1;
                  if (col_ff == 3'd4) begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  row_in = row_ff + 3'd1;
               end
            end else begin
               px_in    = vert_ff ? px_ff : px_ff + 8'd1;
               py_in    = vert_ff ? py_ff + 8'd1 : py_ff;
               len_in   = len_ff - 8'd1;
               state_in = ST_LINE;
            end
         end
         ST_CHAR: begin
            if (glyph_bit && in_range) begin
               rd_en    = 1'b1;
               state_in = ST_RMW;
            end else if (row_ff == 3'd6) begin
               row_in = 3'd0;
               col_in = col_ff + 3'd1;
               if (col_ff == 3'd4) begin
                  state_in = ST_IDLE;
               end
            end else begin
               row_in = row_ff + 3'd1;
            end
         end
         ST_WIN: begin
            if (out_free) begin
               rsp_load     = 1'b1;
               rsp_byte_in  = win_byte(cnt_ff[2:0]);
               rsp_first_in = (cnt_ff == '0);
               rsp_last_in  = (cnt_ff == CNT_W'(6));
               cnt_in       = cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(6)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_HDR: begin
            if (out_free) begin
               rsp_load     = 1'b1;
               rsp_byte_in  = CTRL_DATA;
               rsp_first_in = 1'b1;
               rsp_last_in  = 1'b0;
               state_in     = ST_CHK_RD;
            end
         end
         ST_CHK_RD: begin
            rd_en    = chk_in_fb;
            state_in = ST_CHK_OUT;
         end
         ST_CHK_OUT: begin
            if (out_free) begin
               rsp_load     = 1'b1;
               rsp_byte_in  = chk_in_fb ? rd_data : 8'h00;
               rsp_first_in = 1'b0;
               rsp_last_in  = (cnt_ff == CNT_W'(CHUNK_BYTES - 1));
               cnt_in       = cnt_ff + 1'b1;
               state_in     = rsp_last_in ? ST_IDLE : ST_CHK_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // A fill may start while the last byte of a packet still waits; the
   // clearing pass after reset never has one.
   `MFDE_ASSERT(a_clear_no_rsp, (state_ff == ST_CLEAR && sweep_all_ff) |-> !rsp_valid_ff)
   `MFDE_ASSERT(a_wr_only_sweep_or_rmw,
                wr_en |-> (state_ff == ST_CLEAR || state_ff == ST_RMW))
   `MFDE_ASSERT(a_last_ends_request, (rsp_load && rsp_last_in) |=> (state_ff == ST_IDLE))
   `MFDE_ASSERT(a_first_is_ctrl,
                (rsp_valid_ff && rsp_first_ff) |->
                (rsp_byte_ff == CTRL_CMD || rsp_byte_ff == CTRL_DATA))

endmodule
